/* hdl/falt_pkg.sv */
// Shared constants, payload types and control types of the LRU cache tag engine.
package falt_pkg;

    localparam int WAYS             = 16;
    localparam int BLOCK_BYTES_LOG2 = 6;
    localparam int ADDR_BITS        = 32;

    localparam int ADDR_IN_W  = 32;
    localparam int ADDR_USED  = (ADDR_BITS < ADDR_IN_W) ? ADDR_BITS : ADDR_IN_W;
    localparam int TAG_W      = ADDR_USED - BLOCK_BYTES_LOG2;
    localparam int WAY_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TREE       = 1 << WAY_BITS;
    localparam int FILL_W     = $clog2(WAYS + 1);
    localparam int LVL_W      = $clog2(WAY_BITS + 1);
    localparam int AGE_W      = 32;
    localparam int CNT_W      = 32;
    localparam int QRY_W      = 31;
    localparam int BLK_OUT_W  = 26;
    localparam int WAY_OUT_W  = 4;

    localparam logic [QRY_W-1:0] HALVE_PERIOD = 31'd2147483640;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic                 cmd;
        logic [ADDR_IN_W-1:0] address;
    } t_access;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way_used;
        logic                 writeback_needed;
        logic [BLK_OUT_W-1:0] victim_block;
        logic [BLK_OUT_W-1:0] fill_block;
        logic [CNT_W-1:0]     read_count;
        logic [CNT_W-1:0]     write_count;
        logic [CNT_W-1:0]     read_miss_count;
        logic [CNT_W-1:0]     write_miss_count;
    } t_result;

    typedef struct packed {
        logic load;
        logic look;
        logic reduce;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic full;
    } t_dp_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_REDUCE,
        ST_UPDATE
    } t_state;

endpackage

/* hdl/falt_ctrl.sv */
// Sequencing state machine of the LRU cache tag engine.
module falt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_stall,
    input  falt_pkg::t_dp_status i_sts,
    output falt_pkg::t_dp_cmd   o_cmd,
    output logic                o_in_stall,
    output logic                o_out_valid
);
    import falt_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [LVL_W-1:0] r_lvl;
    logic [LVL_W-1:0] n_lvl;
    logic             r_out_valid;
    logic             n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lvl       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lvl       <= n_lvl;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_lvl       = r_lvl;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_LOOK;
                end
            end
            ST_LOOK: begin
                o_cmd.look = 1'b1;
                n_lvl      = LVL_W'(1);
                if (i_sts.hit || !i_sts.full || (WAY_BITS == 1)) begin
                    n_state = ST_UPDATE;
                end else begin
                    n_state = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                o_cmd.reduce = 1'b1;
                n_lvl        = r_lvl + LVL_W'(1);
                if (r_lvl == LVL_W'(WAY_BITS - 1)) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.update = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

/* hdl/falt_dp.sv */
// Tag store, age counters, victim search tree and statistics of the LRU cache tag engine.
module falt_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  falt_pkg::t_access    i_in_data,
    input  falt_pkg::t_dp_cmd    i_cmd,
    output falt_pkg::t_dp_status o_sts,
    output falt_pkg::t_result    o_out_data
);
    import falt_pkg::*;

    logic [TAG_W-1:0]    r_tag [WAYS];
    logic [WAYS-1:0]     r_valid;
    logic [WAYS-1:0]     r_dirty;
    logic [AGE_W-1:0]    r_age [WAYS];
    logic [AGE_W-1:0]    n_age [WAYS];
    logic [FILL_W-1:0]   r_filled;
    logic [QRY_W-1:0]    r_query;
    logic [CNT_W-1:0]    r_rd_cnt;
    logic [CNT_W-1:0]    r_wr_cnt;
    logic [CNT_W-1:0]    r_rdm_cnt;
    logic [CNT_W-1:0]    r_wrm_cnt;
    logic [CNT_W-1:0]    n_rd_cnt;
    logic [CNT_W-1:0]    n_wr_cnt;
    logic [CNT_W-1:0]    n_rdm_cnt;
    logic [CNT_W-1:0]    n_wrm_cnt;
    logic                r_is_write;
    logic [TAG_W-1:0]    r_blk;
    logic                r_hit;
    logic [WAY_BITS-1:0] r_hit_way;
    logic [WAY_BITS-1:0] r_cidx [TREE];
    logic [AGE_W-1:0]    r_cage [TREE];
    t_result             r_out;

    logic                match_any;
    logic [WAY_BITS-1:0] match_way;
    logic                full;
    logic [WAY_BITS-1:0] way_sel;
    logic                victim_wb;
    logic [QRY_W-1:0]    q_inc;
    logic                halve;

    always_comb begin
        match_any = 1'b0;
        match_way = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_tag[i] == r_blk)) begin
                match_any = 1'b1;
                match_way = WAY_BITS'(i);
            end
        end
    end

    assign full       = (r_filled == FILL_W'(WAYS));
    assign o_sts.hit  = match_any;
    assign o_sts.full = full;

    always_comb begin
        if (r_hit) begin
            way_sel = r_hit_way;
        end else if (full) begin
            way_sel = r_cidx[0];
        end else begin
            way_sel = r_filled[WAY_BITS-1:0];
        end
    end

    assign victim_wb = !r_hit && r_valid[way_sel] && r_dirty[way_sel];
    assign q_inc     = r_query + QRY_W'(1);
    assign halve     = (q_inc == HALVE_PERIOD);

    always_comb begin
        logic [AGE_W-1:0] a;
        for (int i = 0; i < WAYS; i++) begin
            if (way_sel == WAY_BITS'(i)) begin
                a = '0;
            end else if (r_valid[i]) begin
                a = r_age[i] + AGE_W'(1);
            end else begin
                a = r_age[i];
            end
            n_age[i] = halve ? (a >> 1) : a;
        end
    end

    always_comb begin
        n_rd_cnt  = r_rd_cnt;
        n_wr_cnt  = r_wr_cnt;
        n_rdm_cnt = r_rdm_cnt;
        n_wrm_cnt = r_wrm_cnt;
        if (r_is_write == CMD_WRITE) begin
            n_wr_cnt = r_wr_cnt + CNT_W'(1);
            if (!r_hit) begin
                n_wrm_cnt = r_wrm_cnt + CNT_W'(1);
            end
        end else begin
            n_rd_cnt = r_rd_cnt + CNT_W'(1);
            if (!r_hit) begin
                n_rdm_cnt = r_rdm_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_dirty   <= '0;
            r_filled  <= '0;
            r_query   <= '0;
            r_rd_cnt  <= '0;
            r_wr_cnt  <= '0;
            r_rdm_cnt <= '0;
            r_wrm_cnt <= '0;
            for (int i = 0; i < WAYS; i++) begin
                r_age[i] <= '0;
            end
        end else if (i_cmd.update) begin
            for (int i = 0; i < WAYS; i++) begin
                r_age[i] <= n_age[i];
            end
            r_valid[way_sel] <= 1'b1;
            r_dirty[way_sel] <= (r_is_write == CMD_WRITE) || (r_hit && r_dirty[way_sel]);
            if (!r_hit && !full) begin
                r_filled <= r_filled + FILL_W'(1);
            end
            r_query   <= halve ? '0 : q_inc;
            r_rd_cnt  <= n_rd_cnt;
            r_wr_cnt  <= n_wr_cnt;
            r_rdm_cnt <= n_rdm_cnt;
            r_wrm_cnt <= n_wrm_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_write <= i_in_data.cmd;
            r_blk      <= i_in_data.address[ADDR_USED-1:BLOCK_BYTES_LOG2];
            for (int i = 0; i < TREE; i++) begin
                r_cidx[i] <= WAY_BITS'(i);
                if (i < WAYS) begin
                    r_cage[i] <= r_age[i];
                end else begin
                    r_cage[i] <= '0;
                end
            end
        end else if (i_cmd.look || i_cmd.reduce) begin
            for (int i = 0; i < TREE / 2; i++) begin
                if (r_cage[2 * i + 1] > r_cage[2 * i]) begin
                    r_cidx[i] <= r_cidx[2 * i + 1];
                    r_cage[i] <= r_cage[2 * i + 1];
                end else begin
                    r_cidx[i] <= r_cidx[2 * i];
                    r_cage[i] <= r_cage[2 * i];
                end
            end
        end
        if (i_cmd.look) begin
            r_hit     <= match_any;
            r_hit_way <= match_way;
        end
        if (i_cmd.update) begin
            if (!r_hit) begin
                r_tag[way_sel] <= r_blk;
            end
            r_out.hit              <= r_hit;
            r_out.way_used         <= WAY_OUT_W'(way_sel);
            r_out.writeback_needed <= victim_wb;
            r_out.victim_block     <= victim_wb ? BLK_OUT_W'(r_tag[way_sel]) : '0;
            r_out.fill_block       <= BLK_OUT_W'(r_blk);
            r_out.read_count       <= n_rd_cnt;
            r_out.write_count      <= n_wr_cnt;
            r_out.read_miss_count  <= n_rdm_cnt;
            r_out.write_miss_count <= n_wrm_cnt;
        end
    end

    assign o_out_data = r_out;

endmodule

/* hdl/fully_assoc_cache_lru_tags.sv */
// Top level of the fully associative write-back cache tag and LRU replacement engine.
//
// One access (read or write with a byte address) is a transfer on the input
// channel, and every access gives exactly one result transfer on the output
// channel with hit, way used, write-back victim, fill block and statistics.
// The engine works on one access at a time and stalls its input until the
// access has been resolved. A hit or a fill of a free way goes from the input
// transfer through the look state to the update state, which writes the result
// register, and the next access is taken once the engine is back in idle.
// A miss with all ways in use runs the oldest-way search as a registered
// compare tree, one level per cycle, through the look state and then the
// reduce state once for each further level, before the update state.
// The result is held in an output register, so the next access is taken
// while the previous result still waits; a stalled result holds its value
// and the engine waits in the update state before writing a new one over it.
// Synchronous reset empties all ways and clears ages and counters; no
// clearing pass is needed, and the engine leaves reset in its idle state,
// ready to take an input.
module fully_assoc_cache_lru_tags (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  falt_pkg::t_access i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output falt_pkg::t_result o_out_data
);
    import falt_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status sts;

    falt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    falt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

/* hdl/falt_checker.sv */
// Port-level checks of the LRU cache tag engine and their binding to the top level.
module falt_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input falt_pkg::t_access i_in_data,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input falt_pkg::t_result o_out_data
);
    import falt_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("Stalled result changed or was dropped.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("A second access was taken while one was in work.");

    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.hit) |-> !o_out_data.writeback_needed)
        else $error("A hit reported a write-back.");

    a_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.writeback_needed) |-> (o_out_data.victim_block == '0))
        else $error("Victim block is nonzero without a write-back.");

endmodule

bind fully_assoc_cache_lru_tags falt_checker u_falt_checker (.*);
